// ----- design/lrb_pkg.sv -----
// ----------------------------------------------------------------------------
// lrb_pkg
// Shared widths, action codes and structs for the line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package lrb_pkg;

  localparam int COORD_BITS = 12;
  localparam int CW         = COORD_BITS;
  localparam int ERR_W      = COORD_BITS + 3;
  localparam int SPAN_W     = COORD_BITS + 2;
  localparam int CNT_W      = COORD_BITS + 1;
  localparam int COLOUR_W   = 32;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  typedef logic signed [CW-1:0]    coord_t;
  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic [SPAN_W-1:0]       span_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [COLOUR_W-1:0]     colour_t;

  // Line parameters worked out from a load item.
  typedef struct packed {
    logic   axes_swapped;
    logic   minor_step_down;
    coord_t major_pos;
    coord_t minor_pos;
    err_t   error_term;
    span_t  twice_major_span;
    span_t  twice_minor_span;
    cnt_t   pixels_left;
  } line_setup_t;

  typedef struct packed {
    coord_t  x;
    coord_t  y;
    colour_t colour;
    logic    last;
  } pixel_t;

endpackage

`default_nettype wire

// ----- design/lrb_setup.sv -----
// ----------------------------------------------------------------------------
// lrb_setup
// Turns two endpoints into the starting state of a line walk.
// ----------------------------------------------------------------------------
`default_nettype none

module lrb_setup (
  input  wire lrb_pkg::coord_t start_x,
  input  wire lrb_pkg::coord_t start_y,
  input  wire lrb_pkg::coord_t end_x,
  input  wire lrb_pkg::coord_t end_y,
  output lrb_pkg::line_setup_t setup
);

  logic signed [lrb_pkg::CW:0] dx, dy, adx, ady, dmaj, dmin, admin;
  lrb_pkg::coord_t a_maj, a_min, b_maj, b_min;
  lrb_pkg::coord_t p_maj, p_min, q_maj, q_min;
  logic steep, flip;

  always_comb begin
    dx = {end_x[lrb_pkg::CW-1], end_x} - {start_x[lrb_pkg::CW-1], start_x};
    dy = {end_y[lrb_pkg::CW-1], end_y} - {start_y[lrb_pkg::CW-1], start_y};
    adx = dx[lrb_pkg::CW] ? -dx : dx;
    ady = dy[lrb_pkg::CW] ? -dy : dy;
    steep = ady > adx;

    a_maj = steep ? start_y : start_x;
    a_min = steep ? start_x : start_y;
    b_maj = steep ? end_y : end_x;
    b_min = steep ? end_x : end_y;

    // Order the endpoints so the major coordinate rises.
    flip  = a_maj > b_maj;
    p_maj = flip ? b_maj : a_maj;
    p_min = flip ? b_min : a_min;
    q_maj = flip ? a_maj : b_maj;
    q_min = flip ? a_min : b_min;

    dmaj  = {q_maj[lrb_pkg::CW-1], q_maj} - {p_maj[lrb_pkg::CW-1], p_maj};
    dmin  = {q_min[lrb_pkg::CW-1], q_min} - {p_min[lrb_pkg::CW-1], p_min};
    admin = dmin[lrb_pkg::CW] ? -dmin : dmin;

    setup.axes_swapped     = steep;
    setup.minor_step_down  = dmin[lrb_pkg::CW] || (dmin == '0);
    setup.major_pos        = p_maj;
    setup.minor_pos        = p_min;
    setup.error_term       = -lrb_pkg::err_t'(dmaj);
    setup.twice_major_span = {1'b0, dmaj[lrb_pkg::CW-1:0], 1'b0};
    setup.twice_minor_span = {admin, 1'b0};
    setup.pixels_left      = lrb_pkg::cnt_t'(dmaj) + lrb_pkg::cnt_t'(1);
  end

endmodule

`default_nettype wire

// ----- design/lrb_walker.sv -----
// ----------------------------------------------------------------------------
// lrb_walker
// Holds the state of the line in progress and produces one pixel per step.
// ----------------------------------------------------------------------------
`default_nettype none

module lrb_walker (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   fire,
  input  wire                   action,
  input  wire lrb_pkg::line_setup_t setup,
  input  wire lrb_pkg::colour_t colour,
  output logic                  emit,
  output lrb_pkg::pixel_t       pixel,
  output logic                  drawing
);

  logic            axes_swapped;
  logic            minor_step_down;
  lrb_pkg::coord_t major_pos, major_pos_next;
  lrb_pkg::coord_t minor_pos, minor_pos_next;
  lrb_pkg::err_t   error_term, error_term_next, err_sum;
  lrb_pkg::span_t  twice_major_span;
  lrb_pkg::span_t  twice_minor_span;
  lrb_pkg::cnt_t   pixels_left, pixels_left_next;
  lrb_pkg::colour_t line_colour;
  logic            last;
  logic            load;

  assign load = fire && (action == lrb_pkg::ACT_LOAD);
  assign emit = fire && (action == lrb_pkg::ACT_STEP) && drawing;

  always_comb begin
    last = pixels_left <= lrb_pkg::cnt_t'(1);
    pixel.x      = axes_swapped ? minor_pos : major_pos;
    pixel.y      = axes_swapped ? major_pos : minor_pos;
    pixel.colour = line_colour;
    pixel.last   = last;

    major_pos_next = major_pos + lrb_pkg::coord_t'(1);
    err_sum = error_term
            + lrb_pkg::err_t'({{(lrb_pkg::ERR_W-lrb_pkg::SPAN_W){1'b0}}, twice_minor_span});
    // A non-negative error moves the minor coordinate one step.
    if (!err_sum[lrb_pkg::ERR_W-1]) begin
      minor_pos_next  = minor_step_down ? minor_pos - lrb_pkg::coord_t'(1)
                                        : minor_pos + lrb_pkg::coord_t'(1);
      error_term_next = err_sum
          - lrb_pkg::err_t'({{(lrb_pkg::ERR_W-lrb_pkg::SPAN_W){1'b0}}, twice_major_span});
    end else begin
      minor_pos_next  = minor_pos;
      error_term_next = err_sum;
    end
    pixels_left_next = last ? '0 : pixels_left - lrb_pkg::cnt_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drawing <= 1'b0;
    end else if (load) begin
      drawing <= 1'b1;
    end else if (emit && last) begin
      drawing <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      axes_swapped     <= setup.axes_swapped;
      minor_step_down  <= setup.minor_step_down;
      major_pos        <= setup.major_pos;
      minor_pos        <= setup.minor_pos;
      error_term       <= setup.error_term;
      twice_major_span <= setup.twice_major_span;
      twice_minor_span <= setup.twice_minor_span;
      pixels_left      <= setup.pixels_left;
      line_colour      <= colour;
    end else if (emit) begin
      major_pos   <= major_pos_next;
      minor_pos   <= minor_pos_next;
      error_term  <= error_term_next;
      pixels_left <= pixels_left_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/line_raster_bresenham.sv -----
// ----------------------------------------------------------------------------
// line_raster_bresenham
// Integer line rasterizer: a load item sets up a line, each step item
// returns its next pixel with the line colour and a flag on the last pixel.
// ----------------------------------------------------------------------------
// A step item is held in the item register, and its pixel in the output register.
// Throughput: one item per cycle while out_ready does not stall the output; the item
// register feeds the setup and walker logic, which write the output register.
// Reset clears the item and output valid flags and ends any line in progress.
`default_nettype none

module line_raster_bresenham (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire                    action,
  input  wire lrb_pkg::coord_t   start_x,
  input  wire lrb_pkg::coord_t   start_y,
  input  wire lrb_pkg::coord_t   end_x,
  input  wire lrb_pkg::coord_t   end_y,
  input  wire lrb_pkg::colour_t  pixel_colour,
  output logic                   out_valid,
  input  wire                    out_ready,
  output lrb_pkg::coord_t        point_x,
  output lrb_pkg::coord_t        point_y,
  output lrb_pkg::colour_t       point_colour,
  output logic                   final_pixel
);

  logic              item_valid;
  logic              item_action;
  lrb_pkg::coord_t   item_sx, item_sy, item_ex, item_ey;
  lrb_pkg::colour_t  item_colour;
  logic              out_free, fire, emit, drawing;
  lrb_pkg::line_setup_t setup;
  lrb_pkg::pixel_t   pixel;

  assign out_free = !out_valid || out_ready;
  assign fire     = item_valid && out_free;
  assign in_ready = !item_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_action <= action;
      item_sx     <= start_x;
      item_sy     <= start_y;
      item_ex     <= end_x;
      item_ey     <= end_y;
      item_colour <= pixel_colour;
    end
  end

  lrb_setup u_setup (
    .start_x (item_sx),
    .start_y (item_sy),
    .end_x   (item_ex),
    .end_y   (item_ey),
    .setup   (setup)
  );

  lrb_walker u_walker (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .action  (item_action),
    .setup   (setup),
    .colour  (item_colour),
    .emit    (emit),
    .pixel   (pixel),
    .drawing (drawing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      point_x      <= pixel.x;
      point_y      <= pixel.y;
      point_colour <= pixel.colour;
      final_pixel  <= pixel.last;
    end
  end

`ifndef SYNTHESIS
  a_load_no_pixel: assert property (@(posedge clk) disable iff (rst)
    (fire && item_action == lrb_pkg::ACT_LOAD) |=> !out_valid)
    else $error("load item produced a pixel");

  a_idle_step_no_pixel: assert property (@(posedge clk) disable iff (rst)
    (fire && item_action == lrb_pkg::ACT_STEP && !drawing) |=> !out_valid)
    else $error("step without a line produced a pixel");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (emit && pixel.last) |=> !drawing)
    else $error("line still drawing after its last pixel");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (rst)
    (item_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while held item is stalled");

  a_emit_needs_line: assert property (@(posedge clk) disable iff (rst)
    emit |-> (drawing && fire))
    else $error("pixel emitted without a line in progress");
`endif

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for line_raster_bresenham. Load and step items are queued up
// front, fed through a valid/ready driver with random gaps, and every pixel
// that comes back is checked field by field against a Bresenham line walker
// kept inside the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int STIM_ITEMS    = 650;
  localparam int HOLD_AT_ITEM  = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 20;

  typedef struct {
    logic             action;
    lrb_pkg::coord_t  sx;
    lrb_pkg::coord_t  sy;
    lrb_pkg::coord_t  ex;
    lrb_pkg::coord_t  ey;
    lrb_pkg::colour_t colour;
    int unsigned      gap;
    bit               drain;
  } line_cmd_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             action = lrb_pkg::ACT_LOAD;
  lrb_pkg::coord_t  start_x = '0;
  lrb_pkg::coord_t  start_y = '0;
  lrb_pkg::coord_t  end_x = '0;
  lrb_pkg::coord_t  end_y = '0;
  lrb_pkg::colour_t pixel_colour = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  lrb_pkg::coord_t  point_x;
  lrb_pkg::coord_t  point_y;
  lrb_pkg::colour_t point_colour;
  logic             final_pixel;

  line_cmd_t       pending[$];
  line_cmd_t       offered;
  lrb_pkg::pixel_t expected_pixels[$];
  int unsigned     gap_left = 0;
  int unsigned     rx_wait = 0;
  int unsigned     hold_left = 0;
  bit              hold_done = 1'b0;
  int unsigned     items_accepted = 0;
  int unsigned     results_seen = 0;
  int unsigned     mismatches = 0;
  int unsigned     cycles = 0;

  // Line walker state, at the widths the block keeps.
  logic             line_active = 1'b0;
  logic             line_swapped = 1'b0;
  logic             line_down = 1'b0;
  lrb_pkg::coord_t  line_major = '0;
  lrb_pkg::coord_t  line_minor = '0;
  lrb_pkg::err_t    line_err = '0;
  lrb_pkg::span_t   line_tmaj = '0;
  lrb_pkg::span_t   line_tmin = '0;
  lrb_pkg::cnt_t    line_left = '0;
  lrb_pkg::colour_t line_colour = '0;

  line_raster_bresenham u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .pixel_colour (pixel_colour),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_colour (point_colour),
    .final_pixel  (final_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int iabs(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int unsigned draw_gap(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 15);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
    endcase
  endfunction

  // Moves a coordinate by d, going the other way if that would leave the range.
  function automatic lrb_pkg::coord_t shift_coord(lrb_pkg::coord_t c, int d);
    int v;
    v = int'(c) + d;
    if (v > 2047 || v < -2048) v = int'(c) - d;
    return lrb_pkg::coord_t'(v);
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("[%0t] pixel %0d: %s got 0x%0h, want 0x%0h",
             $time, results_seen, field, got, want);
  endtask

  // Queues a load item followed by n_steps step items.
  task automatic add_line(int sx, int sy, int ex, int ey,
                          lrb_pkg::colour_t colour, int n_steps, int gap_mode,
                          bit drain);
    line_cmd_t cmd;
    cmd.action = lrb_pkg::ACT_LOAD;
    cmd.sx = lrb_pkg::coord_t'(sx);
    cmd.sy = lrb_pkg::coord_t'(sy);
    cmd.ex = lrb_pkg::coord_t'(ex);
    cmd.ey = lrb_pkg::coord_t'(ey);
    cmd.colour = colour;
    cmd.gap = draw_gap(gap_mode);
    cmd.drain = drain;
    pending.push_back(cmd);
    for (int i = 0; i < n_steps; i++) begin
      // Coordinates and colour are don't-care on a step item.
      cmd.action = lrb_pkg::ACT_STEP;
      cmd.sx = lrb_pkg::coord_t'($urandom);
      cmd.sy = lrb_pkg::coord_t'($urandom);
      cmd.ex = lrb_pkg::coord_t'($urandom);
      cmd.ey = lrb_pkg::coord_t'($urandom);
      cmd.colour = $urandom;
      cmd.gap = draw_gap(gap_mode);
      cmd.drain = 1'b0;
      pending.push_back(cmd);
    end
  endtask

  task automatic predict_item(line_cmd_t cmd);
    int ax, ay, bx, by, t, dmaj, dmin, e;
    bit steep, last;
    lrb_pkg::coord_t px, py;
    if (cmd.action == lrb_pkg::ACT_LOAD) begin
      ax = int'(cmd.sx);
      ay = int'(cmd.sy);
      bx = int'(cmd.ex);
      by = int'(cmd.ey);
      steep = iabs(by - ay) > iabs(bx - ax);
      if (steep) begin
        t = ax; ax = ay; ay = t;
        t = bx; bx = by; by = t;
      end
      if (ax > bx) begin
        t = ax; ax = bx; bx = t;
        t = ay; ay = by; by = t;
      end
      dmaj = bx - ax;
      dmin = by - ay;
      line_swapped = steep;
      line_down = !(dmin > 0);
      line_major = lrb_pkg::coord_t'(ax);
      line_minor = lrb_pkg::coord_t'(ay);
      line_err = lrb_pkg::err_t'(-dmaj);
      line_tmaj = lrb_pkg::span_t'(2 * dmaj);
      line_tmin = lrb_pkg::span_t'(2 * iabs(dmin));
      line_left = lrb_pkg::cnt_t'(dmaj + 1);
      line_colour = cmd.colour;
      line_active = 1'b1;
    end else if (line_active) begin
      px = line_swapped ? line_minor : line_major;
      py = line_swapped ? line_major : line_minor;
      last = (line_left <= 1);
      expected_pixels.push_back('{x: px, y: py, colour: line_colour, last: last});
      line_major = line_major + lrb_pkg::coord_t'(1);
      e = int'(line_err) + int'(line_tmin);
      if (e >= 0) begin
        line_minor = line_down ? line_minor - lrb_pkg::coord_t'(1)
                               : line_minor + lrb_pkg::coord_t'(1);
        e = e - int'(line_tmaj);
      end
      line_err = lrb_pkg::err_t'(e);
      if (last) begin
        line_left = '0;
        line_active = 1'b0;
      end else begin
        line_left = line_left - lrb_pkg::cnt_t'(1);
      end
    end
  endtask

  // Sender: offers the queued items; a held item only changes once accepted.
  always @(posedge clk) begin : driver
    line_cmd_t cmd;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_item(offered);
        items_accepted <= items_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending.size() != 0 &&
                     !(pending[0].drain && expected_pixels.size() != 0)) begin
          cmd = pending.pop_front();
          offered <= cmd;
          action <= cmd.action;
          start_x <= cmd.sx;
          start_y <= cmd.sy;
          end_x <= cmd.ex;
          end_y <= cmd.ey;
          pixel_colour <= cmd.colour;
          gap_left <= cmd.gap;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // One long receiver stall, so the block backs up and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && items_accepted >= HOLD_AT_ITEM) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: checks each pixel, then draws its wait before the next one.
  always @(posedge clk) begin : monitor
    lrb_pkg::pixel_t want;
    int unsigned w;
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
    end else begin
      w = rx_wait;
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected pixel, x", 32'(point_x), '0);
        end else begin
          want = expected_pixels.pop_front();
          if (point_x !== want.x)
            report_mismatch("point_x", 32'(point_x), 32'(want.x));
          if (point_y !== want.y)
            report_mismatch("point_y", 32'(point_y), 32'(want.y));
          if (point_colour !== want.colour)
            report_mismatch("point_colour", point_colour, want.colour);
          if (final_pixel !== want.last)
            report_mismatch("final_pixel", 32'(final_pixel), 32'(want.last));
        end
        results_seen <= results_seen + 1;
        // Every third band of pixels is taken with no random waits.
        w = (((results_seen / 48) % 3) != 0) ? $urandom_range(0, 15) : 0;
      end else if (w != 0) begin
        w = w - 1;
      end
      rx_wait <= w;
      out_ready <= (w == 0) && (hold_left == 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    lrb_pkg::coord_t sx, sy, ex, ey;
    int     pixels, n_steps, pick, gap_mode;
    bit     drain;

    // Step with no line in progress, right after reset.
    add_line('0, '0, '0, '0, '0, 0, 0, 1'b0);
    pending.delete();
    begin
      line_cmd_t idle_step;
      idle_step = '{lrb_pkg::ACT_STEP, 12'h7FF, 12'h800, 12'h000, 12'hFFF, 32'h0, 0, 1'b0};
      pending.push_back(idle_step);
    end
    // Degenerate line, then a step past its end.
    add_line(5, -7, 5, -7, 32'hFFFF_FFFF, 2, 0, 1'b0);
    // Ends on the top of the x range, so the walk wraps after the last pixel.
    add_line(2044, -2048, 2047, -2045, 32'hA5A5_5A5A, 4, 0, 1'b0);
    // Steep line with a falling minor axis, replaced before it ends.
    add_line(0, 0, -2, 5, 32'h1234_5678, 3, 0, 1'b0);
    // Full-range diagonals, both directions.
    add_line(-2048, 2047, 2047, -2048, 32'h0000_0000, 3, 0, 1'b0);
    add_line(2047, -2048, -2048, 2047, 32'h8000_0001, 1, 0, 1'b0);
    // Flat line given right to left.
    add_line(3, -1, -1, -1, 32'h7FFF_FFFE, 5, 0, 1'b0);

    drain = 1'b1;
    while (pending.size() < STIM_ITEMS) begin
      gap_mode = $urandom_range(0, 2);
      sx = lrb_pkg::coord_t'($urandom);
      sy = lrb_pkg::coord_t'($urandom);
      if ($urandom_range(0, 9) == 0)
        sx = lrb_pkg::coord_t'(2047 - $urandom_range(0, 10));
      if ($urandom_range(0, 9) == 0)
        sy = lrb_pkg::coord_t'(-2048 + $urandom_range(0, 10));
      if ($urandom_range(0, 19) == 0) begin
        ex = lrb_pkg::coord_t'($urandom);
        ey = lrb_pkg::coord_t'($urandom);
      end else begin
        ex = shift_coord(sx, int'($urandom_range(0, 30)) - 15);
        ey = shift_coord(sy, int'($urandom_range(0, 30)) - 15);
      end
      pixels = ((iabs(int'(ex) - int'(sx)) > iabs(int'(ey) - int'(sy))) ?
                iabs(int'(ex) - int'(sx)) : iabs(int'(ey) - int'(sy))) + 1;
      pick = $urandom_range(0, 99);
      if (pixels > 40) n_steps = $urandom_range(0, 40);
      else if (pick < 70) n_steps = pixels;
      else if (pick < 85) n_steps = $urandom_range(0, pixels - 1);
      else n_steps = pixels + $urandom_range(1, 3);
      add_line(int'(sx), int'(sy), int'(ex), int'(ey), $urandom, n_steps,
               gap_mode, drain);
      drain = ($urandom_range(0, 24) == 0);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (pending.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
